// ===== rtl/ritpc_pkg.sv =====
// ritpc_pkg: shared types, constants and graph helper functions for the
// in-tree polynomial count unit; no dependencies
`default_nettype none

package ritpc_pkg;

  localparam int NODES  = 8;
  localparam int NODE_W = 3;
  localparam int MAP_W  = NODES * NODE_W;
  localparam int COEF_W = 6;
  localparam int NUM_W  = 4;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic [NUM_W-1:0] NUM_STATES_RESET = 4'd8;
  localparam logic             REG_NUM_STATES   = 1'b0;

  typedef logic [NODE_W-1:0] node_t;
  typedef node_t [NODES-1:0] node_map_t;
  typedef logic [NODES-1:0]  node_set_t;

  typedef struct packed {
    node_set_t         rest;
    logic [NODE_W-1:0] j;
  } hit_t;

  // r(p) = outer(inner(p))
  function automatic node_map_t compose(node_map_t outer, node_map_t inner);
    node_map_t r;
    for (int p = 0; p < NODES; p++) begin
      r[p] = outer[inner[p]];
    end
    return r;
  endfunction

  // set of images of the members of s under f
  function automatic node_set_t image(node_map_t f, node_set_t s);
    node_set_t r;
    r = '0;
    for (int p = 0; p < NODES; p++) begin
      if (s[p]) begin
        r[f[p]] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ritpc_if.sv =====
// ritpc_item_if, ritpc_result_if: valid/ready channels of the count unit
// depends on ritpc_pkg
`default_nettype none

interface ritpc_item_if;
  logic                     valid;
  logic                     ready;
  logic [ritpc_pkg::MAP_W-1:0] first_map;
  logic [ritpc_pkg::MAP_W-1:0] second_map;

  modport source (output valid, first_map, second_map, input ready);
  modport sink (input valid, first_map, second_map, output ready);
endinterface

interface ritpc_result_if;
  logic                         valid;
  logic                         ready;
  logic [ritpc_pkg::NODE_W-1:0] root_state;
  logic [ritpc_pkg::COEF_W-1:0] coef_0;
  logic [ritpc_pkg::COEF_W-1:0] coef_1;
  logic [ritpc_pkg::COEF_W-1:0] coef_2;
  logic [ritpc_pkg::COEF_W-1:0] coef_3;
  logic [ritpc_pkg::COEF_W-1:0] coef_4;
  logic [ritpc_pkg::COEF_W-1:0] coef_5;
  logic [ritpc_pkg::COEF_W-1:0] coef_6;
  logic [ritpc_pkg::COEF_W-1:0] coef_7;
  logic                         last_root;

  modport source (output valid, root_state, coef_0, coef_1, coef_2, coef_3, coef_4,
                  coef_5, coef_6, coef_7, last_root, input ready);
  modport sink (input valid, root_state, coef_0, coef_1, coef_2, coef_3, coef_4,
                coef_5, coef_6, coef_7, last_root, output ready);
endinterface

`default_nettype wire

// ===== rtl/ritpc_cfg.sv =====
// ritpc_cfg: apb register block holding num_states
// depends on ritpc_pkg
`default_nettype none

module ritpc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ritpc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [ritpc_pkg::DATA_W-1:0]    pwdata,
  output logic      [ritpc_pkg::DATA_W-1:0]    prdata,
  output logic                                 pready,
  output logic      [ritpc_pkg::NUM_W-1:0]     num_states
);

  logic wr_num;

  assign pready = 1'b1;
  assign wr_num = psel && penable && pwrite && (paddr[2] == ritpc_pkg::REG_NUM_STATES);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_states <= ritpc_pkg::NUM_STATES_RESET;
    end else if (wr_num) begin
      num_states <= pwdata[ritpc_pkg::NUM_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ritpc_pkg::REG_NUM_STATES) begin
      prdata = {{(ritpc_pkg::DATA_W - ritpc_pkg::NUM_W){1'b0}}, num_states};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ritpc_graph.sv =====
// ritpc_graph: two-stage unit that checks one letter-choice mask per cycle
// for a single cycle and returns the counted roots; depends on ritpc_pkg
`default_nettype none

module ritpc_graph (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             issue,
  input  wire logic [ritpc_pkg::NODES-1:0]      mask,
  input  wire ritpc_pkg::node_map_t             tgt0,
  input  wire ritpc_pkg::node_map_t             tgt1,
  input  wire logic [ritpc_pkg::NUM_W-1:0]      n,
  output logic                                  busy,
  output logic                                  hit_valid,
  output ritpc_pkg::hit_t                       hit
);

  // stage 1: chosen map and its powers
  ritpc_pkg::node_map_t   g_c;
  ritpc_pkg::node_map_t   g2_c;
  ritpc_pkg::node_map_t   g4_c;
  logic [ritpc_pkg::NUM_W-1:0] z_c;

  ritpc_pkg::node_map_t   g;
  ritpc_pkg::node_map_t   g2;
  ritpc_pkg::node_map_t   g4;
  ritpc_pkg::node_set_t   mask1;
  logic [ritpc_pkg::NODE_W-1:0] j1;
  logic                   v1;

  // stage 2: cycle set and orbit of its least node
  ritpc_pkg::node_map_t   g8_c;
  ritpc_pkg::node_set_t   cyc_c;
  ritpc_pkg::node_set_t   s0_c;
  ritpc_pkg::node_set_t   s1_c;
  ritpc_pkg::node_set_t   s2_c;
  ritpc_pkg::node_set_t   s3_c;
  ritpc_pkg::hit_t        hit_c;

  always_comb begin
    z_c = '0;
    for (int p = 0; p < ritpc_pkg::NODES; p++) begin
      g_c[p] = mask[p] ? tgt1[p] : tgt0[p];
      z_c    = z_c + ritpc_pkg::NUM_W'(mask[p]);
    end
    g2_c = ritpc_pkg::compose(g_c, g_c);
    g4_c = ritpc_pkg::compose(g2_c, g2_c);
  end

  always_ff @(posedge clk) begin
    g     <= g_c;
    g2    <= g2_c;
    g4    <= g4_c;
    mask1 <= mask;
    j1    <= ritpc_pkg::NODE_W'(n - z_c - 4'd1);
    hit   <= hit_c;
  end

  always_comb begin
    g8_c  = ritpc_pkg::compose(g4, g4);
    cyc_c = ritpc_pkg::image(g8_c, '1);
    s0_c  = cyc_c & (~cyc_c + ritpc_pkg::NODES'(1));
    s1_c  = s0_c | ritpc_pkg::image(g, s0_c);
    s2_c  = s1_c | ritpc_pkg::image(g2, s1_c);
    s3_c  = s2_c | ritpc_pkg::image(g4, s2_c);
    hit_c.j    = j1;
    hit_c.rest = (s3_c == cyc_c) ? (cyc_c & ~mask1) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      hit_valid <= 1'b0;
    end else begin
      v1        <= issue;
      hit_valid <= v1;
    end
  end

  assign busy = v1 || hit_valid;

endmodule

`default_nettype wire

// ===== rtl/rooted_in_tree_polynomial_count_unit.sv =====
// rooted_in_tree_polynomial_count_unit: top level with sequencer, per-root
// coefficient counters and output register; depends on ritpc_pkg, ritpc_if,
// ritpc_cfg and ritpc_graph
//
// One item is taken while the unit is idle. It then walks all 2^n letter-choice
// masks, one per cycle through the two-stage graph unit, and after a drain of
// the graph unit sends n results, one per root, at one per cycle when the sink
// keeps ready high. The mask walk through the single graph unit sets the pace of
// input transfers. num_states is read when an item is taken.
`default_nettype none

module rooted_in_tree_polynomial_count_unit #(
  parameter int MAX_STATES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ritpc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [ritpc_pkg::DATA_W-1:0]  pwdata,
  output logic      [ritpc_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  ritpc_item_if.sink                         item,
  ritpc_result_if.source                     result
);

  localparam int MASK_W = MAX_STATES + 1;
  localparam int Q_W    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam logic [ritpc_pkg::NUM_W-1:0] MAX_N = ritpc_pkg::NUM_W'(MAX_STATES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                   state;
  logic [ritpc_pkg::NUM_W-1:0]  num_states;
  logic [ritpc_pkg::NUM_W-1:0]  n_eff;
  logic [ritpc_pkg::NUM_W-1:0]  n_run;
  ritpc_pkg::node_map_t         tgt0;
  ritpc_pkg::node_map_t         tgt1;
  ritpc_pkg::node_map_t         tgt0_next;
  ritpc_pkg::node_map_t         tgt1_next;
  logic [MASK_W-1:0]            mask_cnt;
  logic                         last_mask;
  logic [Q_W-1:0]               q_cnt;
  logic                         last_q;
  logic                         accept;
  logic                         issue;
  logic                         busy;
  logic                         hit_valid;
  ritpc_pkg::hit_t              hit;
  logic                         load;

  logic [ritpc_pkg::COEF_W-1:0] cnt [MAX_STATES][ritpc_pkg::NODES];
  logic [ritpc_pkg::COEF_W-1:0] coef [ritpc_pkg::NODES];
  logic [ritpc_pkg::NODE_W-1:0] root;
  logic                         last_flag;
  logic                         out_valid;

  ritpc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .num_states (num_states)
  );

  always_comb begin
    n_eff = num_states;
    if (num_states < 4'd2) begin
      n_eff = 4'd2;
    end else if (num_states > MAX_N) begin
      n_eff = MAX_N;
    end
  end

  // saturate targets, unused states point at node 0
  always_comb begin
    for (int p = 0; p < ritpc_pkg::NODES; p++) begin
      tgt0_next[p] = item.first_map[p*ritpc_pkg::NODE_W +: ritpc_pkg::NODE_W];
      tgt1_next[p] = item.second_map[p*ritpc_pkg::NODE_W +: ritpc_pkg::NODE_W];
      if ({1'b0, tgt0_next[p]} >= n_eff) begin
        tgt0_next[p] = ritpc_pkg::NODE_W'(n_eff - 4'd1);
      end
      if ({1'b0, tgt1_next[p]} >= n_eff) begin
        tgt1_next[p] = ritpc_pkg::NODE_W'(n_eff - 4'd1);
      end
      if (ritpc_pkg::NUM_W'(p) >= n_eff) begin
        tgt0_next[p] = '0;
        tgt1_next[p] = '0;
      end
    end
  end

  assign item.ready = (state == ST_IDLE);
  assign accept     = item.valid && item.ready;
  assign issue      = (state == ST_RUN);
  assign last_mask  = (mask_cnt == ((MASK_W'(1) << n_run) - MASK_W'(1)));
  assign last_q     = (ritpc_pkg::NUM_W'(q_cnt) == n_run - 4'd1);
  assign load       = (state == ST_EMIT) && (!out_valid || result.ready);

  ritpc_graph u_graph (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .mask      (ritpc_pkg::NODES'(mask_cnt)),
    .tgt0      (tgt0),
    .tgt1      (tgt1),
    .n         (n_run),
    .busy      (busy),
    .hit_valid (hit_valid),
    .hit       (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_mask) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (!busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load && last_q) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n_run    <= n_eff;
      tgt0     <= tgt0_next;
      tgt1     <= tgt1_next;
      mask_cnt <= '0;
      q_cnt    <= '0;
    end else begin
      if (issue) begin
        mask_cnt <= mask_cnt + MASK_W'(1);
      end
      if (load) begin
        q_cnt <= q_cnt + Q_W'(1);
      end
    end
  end

  // coefficient counters, one lane per root
  always_ff @(posedge clk) begin
    for (int q = 0; q < MAX_STATES; q++) begin
      if (accept) begin
        for (int j = 0; j < ritpc_pkg::NODES; j++) begin
          cnt[q][j] <= '0;
        end
      end else if (hit_valid && hit.rest[q]) begin
        cnt[q][hit.j] <= cnt[q][hit.j] + ritpc_pkg::COEF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      root      <= ritpc_pkg::NODE_W'(q_cnt);
      last_flag <= last_q;
      for (int j = 0; j < ritpc_pkg::NODES; j++) begin
        coef[j] <= cnt[q_cnt][j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid      = out_valid;
  assign result.root_state = root;
  assign result.coef_0     = coef[0];
  assign result.coef_1     = coef[1];
  assign result.coef_2     = coef[2];
  assign result.coef_3     = coef[3];
  assign result.coef_4     = coef[4];
  assign result.coef_5     = coef[5];
  assign result.coef_6     = coef[6];
  assign result.coef_7     = coef[7];
  assign result.last_root  = last_flag;

endmodule

`default_nettype wire

// ===== tb/rooted_in_tree_polynomial_count_unit_test.sv =====
// rooted_in_tree_polynomial_count_unit_test: directed table and random transfers
// under bursty sending and receiver stalls, each root result checked against a local
// in-tree counter or a typed row; depends on ritpc_pkg, ritpc_if and the count unit
`default_nettype none

module rooted_in_tree_polynomial_count_unit_test;

  localparam int MAX_STATES        = ritpc_pkg::NODES;
  localparam int CYCLE_LIMIT       = 1000000;
  localparam int ITEMS_PER_SETTING = 29;
  localparam int TAIL_CYCLES       = 40;
  localparam int NUM_SETTINGS      = 11;

  localparam logic [ritpc_pkg::ADDR_W-1:0] NUM_STATES_ADDR =
    ritpc_pkg::ADDR_W'(4 * ritpc_pkg::REG_NUM_STATES);

  localparam logic [0:7][ritpc_pkg::COEF_W-1:0] BINOMIAL_7 = '{6'd1, 6'd7, 6'd21, 6'd35,
                                                                6'd35, 6'd21, 6'd7, 6'd1};
  localparam logic [0:7][ritpc_pkg::COEF_W-1:0] ONLY_J0 = '{6'd1, 6'd0, 6'd0, 6'd0,
                                                             6'd0, 6'd0, 6'd0, 6'd0};
  localparam logic [0:7][ritpc_pkg::COEF_W-1:0] ONLY_J7 = '{6'd0, 6'd0, 6'd0, 6'd0,
                                                             6'd0, 6'd0, 6'd0, 6'd1};

  typedef enum logic [1:0] {READY_FLOW, READY_COIN, READY_SPARSE} ready_mode_t;

  typedef struct {
    ritpc_pkg::node_t             root;
    logic [ritpc_pkg::COEF_W-1:0] coef [8];
    logic                         last;
  } root_coefs_t;

  typedef struct packed {
    logic [ritpc_pkg::MAP_W-1:0]       first_map;
    logic [ritpc_pkg::MAP_W-1:0]       second_map;
    logic                              typed;
    ritpc_pkg::node_t                  hub;
    logic [0:7][ritpc_pkg::COEF_W-1:0] hub_coefs;
  } directed_row_t;

  // typed rows hold the only root that may have nonzero counts
  localparam directed_row_t DIRECTED [13] = '{
    '{24'h000000, 24'h000000, 1'b1, 3'd0, BINOMIAL_7},
    '{24'hFFFFFF, 24'hFFFFFF, 1'b1, 3'd7, BINOMIAL_7},
    '{24'hFAC688, 24'hFAC688, 1'b1, 3'd0, '0},
    '{24'h000000, 24'hFAC688, 1'b1, 3'd0, ONLY_J7},
    '{24'hFAC688, 24'h000000, 1'b1, 3'd0, ONLY_J0},
    '{24'hFFFFFF, 24'h000000, 1'b0, 3'd0, '0},
    '{24'h000000, 24'hFFFFFF, 1'b0, 3'd0, '0},
    '{24'hAAAAAA, 24'h555555, 1'b0, 3'd0, '0},
    '{24'h555555, 24'hAAAAAA, 1'b0, 3'd0, '0},
    '{24'h1F58D1, 24'hFAC688, 1'b0, 3'd0, '0},
    '{24'h1F58D1, 24'h000000, 1'b0, 3'd0, '0},
    '{24'h1F58D1, 24'h053977, 1'b0, 3'd0, '0},
    '{24'h123456, 24'hFEDCBA, 1'b0, 3'd0, '0}
  };

  localparam logic [ritpc_pkg::NUM_W-1:0] SETTING_SEQ [NUM_SETTINGS] = '{
    4'd2, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5, 4'd9, 4'd6, 4'd7, 4'd4, 4'd8};

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ritpc_pkg::ADDR_W-1:0]  paddr;
  logic [ritpc_pkg::DATA_W-1:0]  pwdata;
  logic [ritpc_pkg::DATA_W-1:0]  prdata;
  logic                          pready;

  ritpc_item_if   item_ch ();
  ritpc_result_if result_ch ();

  rooted_in_tree_polynomial_count_unit #(.MAX_STATES(MAX_STATES)) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  root_coefs_t                 pending_roots [$];
  logic [ritpc_pkg::NUM_W-1:0] num_states_shadow;
  int                          errors = 0;
  int                          items_sent = 0;
  int                          roots_checked = 0;
  int                          cycle_count = 0;
  int                          burst_left = 0;
  int                          stall_left = 0;
  ready_mode_t                 ready_mode = READY_FLOW;

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rooted_in_tree_polynomial_count_unit verification failed");
      $finish;
    end
  end

  function automatic int used_states(logic [ritpc_pkg::NUM_W-1:0] ns);
    if (ns < 2) return 2;
    if (ns > MAX_STATES) return MAX_STATES;
    return int'(ns);
  endfunction

  // walk every letter choice, keep graphs with a single cycle, tally per root
  function automatic void count_in_trees(logic [ritpc_pkg::MAP_W-1:0] fm,
                                         logic [ritpc_pkg::MAP_W-1:0] sm);
    int                   n;
    int                   cycles;
    int                   z;
    int                   j;
    bit                   lowest;
    ritpc_pkg::node_t     w;
    ritpc_pkg::node_t     step [2][ritpc_pkg::NODES];
    ritpc_pkg::node_t     g [ritpc_pkg::NODES];
    ritpc_pkg::node_set_t on_cycle;
    int                   tally [ritpc_pkg::NODES][8];
    root_coefs_t          r;
    n = used_states(num_states_shadow);
    for (int p = 0; p < ritpc_pkg::NODES; p++) begin
      step[0][p] = fm[3*p +: 3];
      step[1][p] = sm[3*p +: 3];
      for (int k = 0; k < 2; k++) begin
        if (int'(step[k][p]) >= n) step[k][p] = ritpc_pkg::node_t'(n - 1);
      end
      for (int k = 0; k < 8; k++) tally[p][k] = 0;
    end
    for (int m = 0; m < (1 << n); m++) begin
      for (int p = 0; p < n; p++) g[p] = step[(m >> p) & 1][p];
      on_cycle = '0;
      cycles = 0;
      for (int p = 0; p < n; p++) begin
        w = g[p];
        lowest = 1'b1;
        for (int k = 0; k < n; k++) begin
          if (int'(w) == p) begin
            on_cycle[p] = 1'b1;
            if (lowest) cycles++;
            break;
          end
          if (int'(w) < p) lowest = 1'b0;
          w = g[w];
        end
      end
      if (cycles != 1) continue;
      z = $countones(m);
      if (z >= n) continue;
      j = n - z - 1;
      for (int q = 0; q < n; q++) begin
        if (on_cycle[q] && !m[q]) tally[q][j]++;
      end
    end
    for (int q = 0; q < n; q++) begin
      r.root = ritpc_pkg::node_t'(q);
      for (int k = 0; k < 8; k++) r.coef[k] = ritpc_pkg::COEF_W'(tally[q][k]);
      r.last = (q == n - 1);
      pending_roots.push_back(r);
    end
  endfunction

  function automatic void expect_single_hub(ritpc_pkg::node_t hub,
                                            logic [0:7][ritpc_pkg::COEF_W-1:0] coefs);
    int          n;
    root_coefs_t r;
    n = used_states(num_states_shadow);
    for (int q = 0; q < n; q++) begin
      r.root = ritpc_pkg::node_t'(q);
      for (int k = 0; k < 8; k++) begin
        r.coef[k] = (ritpc_pkg::node_t'(q) == hub) ? coefs[k] : '0;
      end
      r.last = (q == n - 1);
      pending_roots.push_back(r);
    end
  endfunction

  function automatic logic [ritpc_pkg::MAP_W-1:0] random_map(int n);
    logic [ritpc_pkg::MAP_W-1:0] m;
    m = ritpc_pkg::MAP_W'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      for (int p = 0; p < n; p++) m[3*p +: 3] = ritpc_pkg::node_t'($urandom_range(0, n - 1));
    end
    return m;
  endfunction

  // all tasks below start and end on a falling edge
  task automatic send_item(logic [ritpc_pkg::MAP_W-1:0] fm, logic [ritpc_pkg::MAP_W-1:0] sm);
    if (burst_left == 0) begin
      item_ch.valid = 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 300)) @(negedge clk);
      else repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    item_ch.valid      = 1'b1;
    item_ch.first_map  = fm;
    item_ch.second_map = sm;
    do @(posedge clk); while (!item_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid = 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [ritpc_pkg::DATA_W-1:0] wdata,
                            output logic [ritpc_pkg::DATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = NUM_STATES_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_num_states();
    logic [ritpc_pkg::DATA_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[ritpc_pkg::NUM_W-1:0] !== num_states_shadow) begin
      $error("num_states: expected %0d, got %0d", num_states_shadow,
             rdata[ritpc_pkg::NUM_W-1:0]);
      errors++;
    end
  endtask

  task automatic write_num_states(logic [ritpc_pkg::NUM_W-1:0] v);
    logic [ritpc_pkg::DATA_W-1:0] rdata;
    apb_access(1'b1, ritpc_pkg::DATA_W'(v), rdata);
    num_states_shadow = v;
    check_num_states();
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (ready_mode)
      READY_FLOW:  result_ch.ready = 1'b1;
      READY_COIN:  result_ch.ready = $urandom_range(0, 1) == 1;
      default:     result_ch.ready = $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk) begin : root_check
    root_coefs_t                  want;
    logic [ritpc_pkg::COEF_W-1:0] got [8];
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = '{result_ch.coef_0, result_ch.coef_1, result_ch.coef_2, result_ch.coef_3,
              result_ch.coef_4, result_ch.coef_5, result_ch.coef_6, result_ch.coef_7};
      if (pending_roots.size() == 0) begin
        $error("root_state: expected nothing, got %0d", result_ch.root_state);
        errors++;
      end else begin
        want = pending_roots.pop_front();
        roots_checked++;
        if (result_ch.root_state !== want.root) begin
          $error("root_state: expected %0d, got %0d", want.root, result_ch.root_state);
          errors++;
        end
        for (int k = 0; k < 8; k++) begin
          if (got[k] !== want.coef[k]) begin
            $error("coef_%0d: expected %0d, got %0d", k, want.coef[k], got[k]);
            errors++;
          end
        end
        if (result_ch.last_root !== want.last) begin
          $error("last_root: expected %0d, got %0d", want.last, result_ch.last_root);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    int tail;
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    item_ch.valid      = 1'b0;
    item_ch.first_map  = '0;
    item_ch.second_map = '0;
    result_ch.ready    = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    num_states_shadow = ritpc_pkg::NUM_STATES_RESET;
    check_num_states();

    foreach (DIRECTED[i]) begin
      send_item(DIRECTED[i].first_map, DIRECTED[i].second_map);
      if (DIRECTED[i].typed) expect_single_hub(DIRECTED[i].hub, DIRECTED[i].hub_coefs);
      else count_in_trees(DIRECTED[i].first_map, DIRECTED[i].second_map);
    end

    foreach (SETTING_SEQ[s]) begin
      drain_results();
      write_num_states(SETTING_SEQ[s]);
      n = used_states(num_states_shadow);
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        logic [ritpc_pkg::MAP_W-1:0] fm;
        logic [ritpc_pkg::MAP_W-1:0] sm;
        fm = random_map(n);
        sm = random_map(n);
        if ($urandom_range(0, 39) == 0) drain_results();
        send_item(fm, sm);
        count_in_trees(fm, sm);
      end
    end

    drain_results();
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end

    $display("%0d automata sent over %0d state-count settings, %0d root results checked",
             items_sent, NUM_SETTINGS + 1, roots_checked);
    if (errors == 0 && pending_roots.size() == 0) begin
      $display("rooted_in_tree_polynomial_count_unit verification clean");
    end else begin
      $display("rooted_in_tree_polynomial_count_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rooted_in_tree_polynomial_count_unit.f =====
rtl/ritpc_pkg.sv
rtl/ritpc_if.sv
rtl/ritpc_cfg.sv
rtl/ritpc_graph.sv
rtl/rooted_in_tree_polynomial_count_unit.sv
tb/rooted_in_tree_polynomial_count_unit_test.sv
